// ===== rtl/dfcsd_pkg.sv =====
// Shared types, widths, register codes and reset values for the cycle-slip detector.
package dfcsd_pkg;

    localparam int ObsW        = 48;   // input observation width, signed
    localparam int DiffW       = 49;   // epoch difference width
    localparam int PairW       = 50;   // difference of two differences
    localparam int CfgW        = 32;   // configuration register width
    localparam int CfgIdxW     = 3;    // configuration index width
    localparam int PpLoW       = 64;   // low partial product, 32x32 unsigned
    localparam int PpHiW       = 50;   // high partial product, 17x33 signed
    localparam int ProdW       = 82;   // full signed product
    localparam int SumW        = 86;   // test sums, no overflow for any input
    localparam int FracBitsDef = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_WAVELENGTH_ONE = 3'd0,
        REG_WAVELENGTH_TWO = 3'd1,
        REG_FREQ_RATIO     = 3'd2,
        REG_WIDE_COEF_ONE  = 3'd3,
        REG_WIDE_COEF_TWO  = 3'd4
    } t_cfg_idx;

    localparam logic [CfgW-1:0] RstWavelengthOne = 32'd817305102;
    localparam logic [CfgW-1:0] RstWavelengthTwo = 32'd1048874892;
    localparam logic [CfgW-1:0] RstFreqRatio     = 32'd21530760;
    localparam logic [CfgW-1:0] RstWideCoefOne   = 32'd10940120;
    localparam logic [CfgW-1:0] RstWideCoefTwo   = 32'd8524755;

    typedef struct packed {
        logic signed [ObsW-1:0] old_code_one;
        logic signed [ObsW-1:0] old_code_two;
        logic signed [ObsW-1:0] old_phase_one;
        logic signed [ObsW-1:0] old_phase_two;
        logic signed [ObsW-1:0] new_code_one;
        logic signed [ObsW-1:0] new_code_two;
        logic signed [ObsW-1:0] new_phase_one;
        logic signed [ObsW-1:0] new_phase_two;
    } t_obs;

    typedef struct packed {
        logic no_slip;
        logic wide_lane_ok;
        logic iono_residual_ok;
        logic geometry_free_ok;
    } t_res;

endpackage

// ===== rtl/dual_freq_cycle_slip_detector_core.sv =====
// Dual-frequency cycle-slip detector: wide-lane, iono residual and geometry-free tests.
//
// Unless stalled, takes one word per cycle of code and phase on two frequencies
// for two epochs (signed Q31.FRAC_BITS) and returns one word of four pass flags
// per input word. Tests: Melbourne-Wubbena wide lane |d(L1-L2) - k1*dC1 - k2*dC2|
// < 3.5 cycles, iono residual |dL1 - r*dL2| < 0.3 cycles, geometry free
// |w1*dL1 - w2*dL2 + dC1 - dC2| <= 3.5 m. All sums are exact, nothing saturates.
// Throughput is one word per clock while o_stall is low. The pipeline has six
// registers: input, epoch differences, partial products, full products, test
// sums, flag register. The 49x32 products are split into a 32x32 and a 17x33
// partial product so each multiplier stays within one stage. The pipeline
// stalls as a whole chain: a stage moves when it is empty or the stage after it
// moves, so o_stall only rises once every stage and the output register are full
// and i_stall is high.
// Configuration writes are always taken (o_cfg_ready is tied high); indexes past
// the last register are dropped. Write registers only while the pipeline is empty.
module dual_freq_cycle_slip_detector_core
    import dfcsd_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // observation words
    input  logic               i_valid,
    output logic               o_stall,
    input  t_obs               i_obs,
    // flag words
    output logic               o_valid,
    input  logic               i_stall,
    output t_res               o_res,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data
);

    // pipeline depth before the flag register
    localparam int NStg  = 5;
    // product lanes
    localparam int NLane = 5;
    localparam int LnK1  = 0;   // dC1 * k1
    localparam int LnK2  = 1;   // dC2 * k2
    localparam int LnR   = 2;   // dL2 * r
    localparam int LnW1  = 3;   // dL1 * w1
    localparam int LnW2  = 4;   // dL2 * w2

    // thresholds at the fraction scale of each sum
    localparam logic signed [SumW-1:0] WlLim = $signed(SumW'(7) << (FRAC_BITS + 23));
    localparam logic signed [SumW-1:0] GfLim = $signed(SumW'(7) << (FRAC_BITS + 31));
    // 10*|x| < 3*2^(F+24)  <=>  |x| <= floor((3*2^(F+24) - 1) / 10)
    localparam logic [63:0] IrCnt = ((64'd3 << (FRAC_BITS + 24)) - 64'd1) / 64'd10;
    localparam logic signed [SumW-1:0] IrLim = $signed(SumW'(IrCnt));

    // ---------------- configuration registers ----------------
    logic [CfgW-1:0] r_wl_one, r_wl_two, r_ratio, r_coef_one, r_coef_two;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl_one   <= RstWavelengthOne;
            r_wl_two   <= RstWavelengthTwo;
            r_ratio    <= RstFreqRatio;
            r_coef_one <= RstWideCoefOne;
            r_coef_two <= RstWideCoefTwo;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WAVELENGTH_ONE: r_wl_one   <= i_cfg_data;
                REG_WAVELENGTH_TWO: r_wl_two   <= i_cfg_data;
                REG_FREQ_RATIO:     r_ratio    <= i_cfg_data;
                REG_WIDE_COEF_ONE:  r_coef_one <= i_cfg_data;
                REG_WIDE_COEF_TWO:  r_coef_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic [NStg-1:0] r_vld;
    logic            r_out_vld;
    logic [NStg-1:0] stg_en;
    logic            out_en;

    always_comb begin
        out_en    = !r_out_vld || !i_stall;
        stg_en[4] = !r_vld[4] || out_en;
        stg_en[3] = !r_vld[3] || stg_en[4];
        stg_en[2] = !r_vld[2] || stg_en[3];
        stg_en[1] = !r_vld[1] || stg_en[2];
        stg_en[0] = !r_vld[0] || stg_en[1];
    end

    assign o_stall = !stg_en[0];
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (stg_en[0]) r_vld[0] <= i_valid;
            if (stg_en[1]) r_vld[1] <= r_vld[0];
            if (stg_en[2]) r_vld[2] <= r_vld[1];
            if (stg_en[3]) r_vld[3] <= r_vld[2];
            if (stg_en[4]) r_vld[4] <= r_vld[3];
            if (out_en)    r_out_vld <= r_vld[4];
        end
    end

    // ---------------- stage 0: input word ----------------
    t_obs r_obs;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) r_obs <= i_obs;
    end

    // ---------------- stage 1: epoch differences ----------------
    logic signed [DiffW-1:0] n_dc1, n_dc2, n_dl1, n_dl2;
    logic signed [DiffW-1:0] r_dc1, r_dc2, r_dl1, r_dl2;

    always_comb begin
        n_dc1 = DiffW'(r_obs.new_code_one)  - DiffW'(r_obs.old_code_one);
        n_dc2 = DiffW'(r_obs.new_code_two)  - DiffW'(r_obs.old_code_two);
        n_dl1 = DiffW'(r_obs.new_phase_one) - DiffW'(r_obs.old_phase_one);
        n_dl2 = DiffW'(r_obs.new_phase_two) - DiffW'(r_obs.old_phase_two);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_dc1 <= n_dc1;
            r_dc2 <= n_dc2;
            r_dl1 <= n_dl1;
            r_dl2 <= n_dl2;
        end
    end

    // ---------------- stage 2: partial products ----------------
    // d * u = (d[48:32] * u) << 32 + d[31:0] * u, d signed, u unsigned
    logic signed [DiffW-1:0] ln_d [NLane];
    logic        [CfgW-1:0]  ln_u [NLane];
    logic signed [PpHiW-1:0] n_pp_hi [NLane];
    logic        [PpLoW-1:0] n_pp_lo [NLane];
    logic signed [PpHiW-1:0] r_pp_hi [NLane];
    logic        [PpLoW-1:0] r_pp_lo [NLane];
    logic signed [PairW-1:0] n_dl12, n_dc12;
    logic signed [DiffW-1:0] r_dl1_p;
    logic signed [PairW-1:0] r_dl12_p, r_dc12_p;

    always_comb begin
        ln_d[LnK1] = r_dc1;  ln_u[LnK1] = r_coef_one;
        ln_d[LnK2] = r_dc2;  ln_u[LnK2] = r_coef_two;
        ln_d[LnR]  = r_dl2;  ln_u[LnR]  = r_ratio;
        ln_d[LnW1] = r_dl1;  ln_u[LnW1] = r_wl_one;
        ln_d[LnW2] = r_dl2;  ln_u[LnW2] = r_wl_two;
        for (int k = 0; k < NLane; k++) begin
            n_pp_hi[k] = PpHiW'($signed(ln_d[k][DiffW-1:32]))
                         * PpHiW'($signed({1'b0, ln_u[k]}));
            n_pp_lo[k] = PpLoW'(ln_d[k][31:0]) * PpLoW'(ln_u[k]);
        end
        n_dl12 = PairW'(r_dl1) - PairW'(r_dl2);
        n_dc12 = PairW'(r_dc1) - PairW'(r_dc2);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_pp_hi  <= n_pp_hi;
            r_pp_lo  <= n_pp_lo;
            r_dl1_p  <= r_dl1;
            r_dl12_p <= n_dl12;
            r_dc12_p <= n_dc12;
        end
    end

    // ---------------- stage 3: full products ----------------
    logic signed [ProdW-1:0] n_prod [NLane];
    logic signed [ProdW-1:0] r_prod [NLane];
    logic signed [DiffW-1:0] r_dl1_q;
    logic signed [PairW-1:0] r_dl12_q, r_dc12_q;

    always_comb begin
        for (int k = 0; k < NLane; k++) begin
            n_prod[k] = (ProdW'(r_pp_hi[k]) <<< 32) + $signed(ProdW'(r_pp_lo[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_prod   <= n_prod;
            r_dl1_q  <= r_dl1_p;
            r_dl12_q <= r_dl12_p;
            r_dc12_q <= r_dc12_p;
        end
    end

    // ---------------- stage 4: test sums ----------------
    // wide lane and iono at F+24 fraction bits, geometry free at F+32
    logic signed [SumW-1:0] n_wl, n_ir, n_gf;
    logic signed [SumW-1:0] r_wl, r_ir, r_gf;

    always_comb begin
        n_wl = (SumW'(r_dl12_q) <<< 24) - SumW'(r_prod[LnK1]) - SumW'(r_prod[LnK2]);
        n_ir = (SumW'(r_dl1_q) <<< 24) - SumW'(r_prod[LnR]);
        n_gf = SumW'(r_prod[LnW1]) - SumW'(r_prod[LnW2]) + (SumW'(r_dc12_q) <<< 32);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_wl <= n_wl;
            r_ir <= n_ir;
            r_gf <= n_gf;
        end
    end

    // ---------------- output: magnitude compares ----------------
    t_res n_res;
    t_res r_res;

    always_comb begin
        n_res.wide_lane_ok     = (r_wl < WlLim) && (r_wl > -WlLim);
        n_res.iono_residual_ok = (r_ir <= IrLim) && (r_ir >= -IrLim);
        n_res.geometry_free_ok = (r_gf <= GfLim) && (r_gf >= -GfLim);
        n_res.no_slip          = n_res.wide_lane_ok && n_res.iono_residual_ok
                                 && n_res.geometry_free_ok;
    end

    always_ff @(posedge i_clk) begin
        if (out_en) r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== rtl/dfcsd_checker.sv =====
// Port-level checker for the cycle-slip detector, bound to the detector core.
module dfcsd_checker
    import dfcsd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_res o_res
);

    // held flag word stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("flag word changed while stalled");

    // summary flag matches the three tests
    a_flag_and: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.no_slip == (o_res.wide_lane_ok && o_res.iono_residual_ok
                                      && o_res.geometry_free_ok))
        else $error("no_slip disagrees with test flags");

    // input side only stalls when the output is full and held
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output can move");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind dual_freq_cycle_slip_detector_core dfcsd_checker u_dfcsd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
